// File: sv/sps_pkg.sv
// Shared types and constants of the slotted page store.
package sps_pkg;

	// Fixed field widths of the channels
	localparam int OP_W      = 2;
	localparam int SLOT_W    = 10;
	localparam int LEN_W     = 12;
	localparam int DATA_W    = 8;
	localparam int STATUS_W  = 3;
	localparam int PAGE_NO_W = 32;

	// Slot directory geometry
	localparam int SLOT_BYTES = 4;
	localparam int MAX_SLOTS  = 1024;
	localparam int TT_W       = 11;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_BAD_SLOT = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_BEYOND   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_STORE = 2'd1,
		MODE_DROP  = 2'd2
	} ins_mode_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SLOT = 2'd1,
		S_BYTE = 2'd2
	} state_t;

	// One result transaction, without the page number
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [DATA_W-1:0]   data_byte;
		logic [LEN_W-1:0]    size;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic slot_done;
		logic byte_done;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic lookup;
		logic slot_final;
	} dp_stat_t;

endpackage

// File: sv/sps_req_if.sv
// Request channel of the slotted page store.
interface sps_req_if;
	logic                          valid;
	logic                          ready;
	logic [sps_pkg::OP_W-1:0]      operation;
	logic [sps_pkg::SLOT_W-1:0]    slot_index;
	logic [sps_pkg::LEN_W-1:0]     byte_index;
	logic [sps_pkg::LEN_W-1:0]     tuple_length;
	logic [sps_pkg::DATA_W-1:0]    data_in;

	modport source(output valid, operation, slot_index, byte_index, tuple_length, data_in,
		input ready);
	modport sink(input valid, operation, slot_index, byte_index, tuple_length, data_in,
		output ready);
endinterface

// File: sv/sps_rsp_if.sv
// Result channel of the slotted page store.
interface sps_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [sps_pkg::STATUS_W-1:0]    result_status;
	logic [sps_pkg::SLOT_W-1:0]      result_slot;
	logic [sps_pkg::DATA_W-1:0]      result_byte;
	logic [sps_pkg::LEN_W-1:0]       result_size;
	logic [sps_pkg::PAGE_NO_W-1:0]   result_page;

	modport source(output valid, result_status, result_slot, result_byte, result_size,
		result_page, input ready);
	modport sink(input valid, result_status, result_slot, result_byte, result_size,
		result_page, output ready);
endinterface

// File: sv/sps_cfg_if.sv
// Configuration write channel of the slotted page store.
interface sps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sps_pkg::PAGE_NO_W-1:0]   page_number;

	modport source(output valid, page_number, input ready);
	modport sink(input valid, page_number, output ready);
endinterface

// File: sv/slotted_page_store.sv
// Top level of the slotted page store: controller, datapath, result queue.
// Usage:
//   req carries one transaction per item: insert byte, read byte, delete slot
//   or clear page. Inserts stream one byte per transaction with the tuple
//   length repeated on each; the last byte (or a rejected first byte)
//   returns a result, other insert bytes return none.
//   rsp returns at most one result per request, in request order, with the
//   configured page number attached. cfg writes the page number; it is always
//   ready. The user must write it only while idle; the block does not enforce it.
// Sequencing:
//   Insert, clear and out-of-range slot requests push their result on acceptance;
//   the result is visible the cycle after acceptance. Other reads and deletes
//   first read the slot directory: a delete, or a read answered from the slot
//   entry, is answered from the registered entry; a read that returns a byte
//   also reads the page memory. req is not ready while a lookup is in progress.
// Stalls and reset:
//   Results wait in a two-entry queue; req is ready only while it has a free
//   entry. arst_n empties the page and the queue and ends any insert; memory
//   contents are not cleared and are never read before being written.
module slotted_page_store #(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	sps_req_if.sink      req,
	sps_rsp_if.source    rsp,
	sps_cfg_if.sink      cfg
);

	sps_pkg::ctrl_cmd_t             cmd;
	sps_pkg::dp_stat_t              stat;
	sps_pkg::res_t                  res, q_dout;
	logic                           res_push, q_space, q_valid, in_ready;
	logic [sps_pkg::PAGE_NO_W-1:0]  page_number_q;

	// Page number register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_number_q <= '0;
		end else if (cfg.valid) begin
			page_number_q <= cfg.page_number;
		end
	end

	sps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.q_space  (q_space),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	sps_dp #(
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (sps_pkg::op_t'(req.operation)),
		.slot_index   (req.slot_index),
		.byte_index   (req.byte_index),
		.tuple_length (req.tuple_length),
		.data_in      (req.data_in),
		.stat         (stat),
		.res_push     (res_push),
		.res          (res)
	);

	sps_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.ready  (rsp.ready),
		.valid  (q_valid),
		.dout   (q_dout),
		.space  (q_space)
	);

	// Drive result channel
	assign rsp.valid         = q_valid;
	assign rsp.result_status = q_dout.status;
	assign rsp.result_slot   = q_dout.slot;
	assign rsp.result_byte   = q_dout.data_byte;
	assign rsp.result_size   = q_dout.size;
	assign rsp.result_page   = page_number_q;

`ifndef SYNTH
	// A result never arrives at a full queue
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> q_space)
		else $error("result pushed into full queue");

	// A slot lookup finishes in the next cycle
	a_lookup_next: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && stat.lookup) |=> cmd.slot_done)
		else $error("slot lookup did not follow acceptance");

	// A read that passes the slot checks returns its byte in the next cycle
	a_byte_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.slot_done && !stat.slot_final) |=> (cmd.byte_done && res_push))
		else $error("byte read gave no result");
`endif

endmodule

// File: sv/sps_ctrl.sv
// Controller state machine: accepts requests and sequences slot and byte lookups.
module sps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                q_space,
	input  sps_pkg::dp_stat_t   stat,
	output logic                in_ready,
	output sps_pkg::ctrl_cmd_t  cmd
);

	sps_pkg::state_t state_q, state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sps_pkg::S_IDLE: begin
				if (cmd.take && stat.lookup) begin
					state_d = sps_pkg::S_SLOT;
				end
			end
			sps_pkg::S_SLOT: begin
				state_d = stat.slot_final ? sps_pkg::S_IDLE : sps_pkg::S_BYTE;
			end
			sps_pkg::S_BYTE: begin
				state_d = sps_pkg::S_IDLE;
			end
			default: begin
				state_d = sps_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd.take      = 1'b0;
		cmd.slot_done = 1'b0;
		cmd.byte_done = 1'b0;
		case (state_q)
			sps_pkg::S_IDLE: begin
				in_ready = q_space;
				cmd.take = q_space && in_valid;
			end
			sps_pkg::S_SLOT: begin
				cmd.slot_done = 1'b1;
			end
			sps_pkg::S_BYTE: begin
				cmd.byte_done = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: sv/sps_dp.sv
// Datapath: page memory, slot directory, pointers and insert tracking.
module sps_dp #(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sps_pkg::ctrl_cmd_t            cmd,
	input  sps_pkg::op_t                  op,
	input  logic [sps_pkg::SLOT_W-1:0]    slot_index,
	input  logic [sps_pkg::LEN_W-1:0]     byte_index,
	input  logic [sps_pkg::LEN_W-1:0]     tuple_length,
	input  logic [sps_pkg::DATA_W-1:0]    data_in,
	output sps_pkg::dp_stat_t             stat,
	output logic                          res_push,
	output sps_pkg::res_t                 res
);

	localparam int PW = $clog2(PAGE_BYTES);
	localparam int AW = $clog2(PAGE_BYTES + 1);
	localparam int SW = (AW > 13) ? AW : 13;
	localparam int EW = PW + sps_pkg::LEN_W;
	localparam int TW = sps_pkg::TT_W;
	localparam int LW = sps_pkg::LEN_W;
	localparam logic [AW-1:0] PAGE_END  = AW'(PAGE_BYTES);
	localparam logic [SW-1:0] HDR       = SW'(HEADER_BYTES);
	localparam logic [SW-1:0] SLOT_SZ   = SW'(sps_pkg::SLOT_BYTES);
	localparam logic [TW-1:0] SLOT_LIM  = TW'(sps_pkg::MAX_SLOTS);

	// Memories
	logic [sps_pkg::DATA_W-1:0] page_mem [PAGE_BYTES];
	logic [EW-1:0]              slot_mem [sps_pkg::MAX_SLOTS];
	logic [sps_pkg::DATA_W-1:0] page_rd_q;
	logic [EW-1:0]              slot_rd_q;

	// Page state
	logic [TW-1:0]          tt_q, tt_d;
	logic [AW-1:0]          fp_q, fp_d;
	logic [AW-1:0]          ins_addr_q, ins_addr_d;
	logic [LW-1:0]          len_q, len_d;
	logic [LW-1:0]          rem_q, rem_d;
	logic [PW-1:0]          wr_addr_q, wr_addr_d;
	sps_pkg::ins_mode_t     mode_q, mode_d;

	// Lookup context
	sps_pkg::op_t               op_q;
	logic [sps_pkg::SLOT_W-1:0] slot_q;
	logic [LW-1:0]              bidx_q;

	// Memory ports
	logic                        pg_we, pg_re, sl_we, sl_re;
	logic [PW-1:0]               pg_waddr, pg_raddr;
	logic [sps_pkg::DATA_W-1:0]  pg_wdata;
	logic [sps_pkg::SLOT_W-1:0]  sl_waddr;
	logic [EW-1:0]               sl_wdata;

	// Space check and helpers
	logic [SW-1:0]  used, fp_w;
	logic           no_space, bad_slot;
	logic [AW-1:0]  new_addr;
	logic [PW-1:0]  ent_off;
	logic [LW-1:0]  ent_size;
	logic           commit;
	logic [AW-1:0]  commit_addr;
	logic [LW-1:0]  commit_size;

	assign used     = HDR + SW'(tt_q) * SLOT_SZ;
	assign fp_w     = SW'(fp_q);
	assign no_space = (tt_q >= SLOT_LIM) || (fp_w < used)
		|| ((fp_w - used) < (SW'(tuple_length) + SLOT_SZ));
	assign new_addr = fp_q - AW'(tuple_length);
	assign bad_slot = TW'(slot_index) >= tt_q;

	assign ent_off  = slot_rd_q[PW-1:0];
	assign ent_size = slot_rd_q[EW-1:PW];

	assign stat.lookup     = ((op == sps_pkg::OP_READ) || (op == sps_pkg::OP_DELETE)) && !bad_slot;
	assign stat.slot_final = (op_q == sps_pkg::OP_DELETE) || (ent_size == '0)
		|| (bidx_q >= ent_size);

	assign sl_re    = cmd.take && stat.lookup;
	assign pg_re    = cmd.slot_done && !stat.slot_final;
	assign pg_raddr = ent_off + PW'(bidx_q);

	// Per-transaction update of pointers, memories and result
	always_comb begin
		tt_d        = tt_q;
		fp_d        = fp_q;
		ins_addr_d  = ins_addr_q;
		len_d       = len_q;
		rem_d       = rem_q;
		wr_addr_d   = wr_addr_q;
		mode_d      = mode_q;
		pg_we       = 1'b0;
		pg_waddr    = wr_addr_q;
		pg_wdata    = data_in;
		sl_we       = 1'b0;
		sl_waddr    = tt_q[sps_pkg::SLOT_W-1:0];
		sl_wdata    = '0;
		res_push    = 1'b0;
		res         = '0;
		res.status  = sps_pkg::ST_OK;
		commit      = 1'b0;
		commit_addr = ins_addr_q;
		commit_size = len_q;

		if (cmd.take) begin
			case (op)
				sps_pkg::OP_INSERT: begin
					case (mode_q)
						sps_pkg::MODE_DROP: begin
							// Swallow a byte of a rejected tuple
							rem_d = rem_q - 1'b1;
							if (rem_q == LW'(1)) begin
								mode_d = sps_pkg::MODE_IDLE;
							end
						end
						sps_pkg::MODE_STORE: begin
							pg_we     = 1'b1;
							wr_addr_d = wr_addr_q + 1'b1;
							if (rem_q <= LW'(1)) begin
								commit = 1'b1;
							end else begin
								rem_d = rem_q - 1'b1;
							end
						end
						default: begin
							// First byte: check room for tuple plus slot
							if (no_space) begin
								res_push    = 1'b1;
								res.status  = sps_pkg::ST_NO_SPACE;
								res.size    = tuple_length;
								if (tuple_length > LW'(1)) begin
									mode_d = sps_pkg::MODE_DROP;
									rem_d  = tuple_length - 1'b1;
								end
							end else begin
								ins_addr_d  = new_addr;
								commit_addr = new_addr;
								commit_size = tuple_length;
								if (tuple_length == '0) begin
									commit = 1'b1;
								end else begin
									pg_we    = 1'b1;
									pg_waddr = new_addr[PW-1:0];
									if (tuple_length == LW'(1)) begin
										commit = 1'b1;
									end else begin
										mode_d    = sps_pkg::MODE_STORE;
										rem_d     = tuple_length - 1'b1;
										len_d     = tuple_length;
										wr_addr_d = new_addr[PW-1:0] + 1'b1;
									end
								end
							end
						end
					endcase
				end
				sps_pkg::OP_CLEAR: begin
					mode_d   = sps_pkg::MODE_IDLE;
					rem_d    = '0;
					tt_d     = '0;
					fp_d     = PAGE_END;
					res_push = 1'b1;
				end
				default: begin
					// Read or delete: drop any partial insert
					mode_d = sps_pkg::MODE_IDLE;
					rem_d  = '0;
					if (bad_slot) begin
						res_push   = 1'b1;
						res.status = sps_pkg::ST_BAD_SLOT;
						res.slot   = slot_index;
					end
				end
			endcase
		end else if (cmd.slot_done) begin
			res.slot = slot_q;
			if (op_q == sps_pkg::OP_DELETE) begin
				// Leave a tombstone: keep offset, zero size
				sl_we    = 1'b1;
				sl_waddr = slot_q;
				sl_wdata = {LW'(0), ent_off};
				res_push = 1'b1;
				res.size = ent_size;
			end else if (ent_size == '0) begin
				res_push   = 1'b1;
				res.status = sps_pkg::ST_EMPTY;
			end else if (bidx_q >= ent_size) begin
				res_push   = 1'b1;
				res.status = sps_pkg::ST_BEYOND;
				res.size   = ent_size;
			end
		end else if (cmd.byte_done) begin
			res_push      = 1'b1;
			res.slot      = slot_q;
			res.data_byte = page_rd_q;
			res.size      = ent_size;
		end

		// Commit the tuple into the next slot
		if (commit) begin
			sl_we      = 1'b1;
			sl_waddr   = tt_q[sps_pkg::SLOT_W-1:0];
			sl_wdata   = {commit_size, commit_addr[PW-1:0]};
			fp_d       = commit_addr;
			tt_d       = tt_q + 1'b1;
			mode_d     = sps_pkg::MODE_IDLE;
			rem_d      = '0;
			res_push   = 1'b1;
			res.status = sps_pkg::ST_OK;
			res.slot   = tt_q[sps_pkg::SLOT_W-1:0];
			res.size   = commit_size;
		end
	end

	// Hold page state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tt_q       <= '0;
			fp_q       <= PAGE_END;
			ins_addr_q <= '0;
			len_q      <= '0;
			rem_q      <= '0;
			wr_addr_q  <= '0;
			mode_q     <= sps_pkg::MODE_IDLE;
		end else begin
			tt_q       <= tt_d;
			fp_q       <= fp_d;
			ins_addr_q <= ins_addr_d;
			len_q      <= len_d;
			rem_q      <= rem_d;
			wr_addr_q  <= wr_addr_d;
			mode_q     <= mode_d;
		end
	end

	// Latch lookup context
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= op;
			slot_q <= slot_index;
			bidx_q <= byte_index;
		end
	end

	// Page memory
	always_ff @(posedge clk) begin
		if (pg_we) begin
			page_mem[pg_waddr] <= pg_wdata;
		end
		if (pg_re) begin
			page_rd_q <= page_mem[pg_raddr];
		end
	end

	// Slot directory
	always_ff @(posedge clk) begin
		if (sl_we) begin
			slot_mem[sl_waddr] <= sl_wdata;
		end
		if (sl_re) begin
			slot_rd_q <= slot_mem[slot_index];
		end
	end

endmodule

// File: sv/sps_outq.sv
// Two-entry result queue between the datapath and the result channel.
module sps_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sps_pkg::res_t  din,
	input  logic           ready,
	output logic           valid,
	output sps_pkg::res_t  dout,
	output logic           space
);

	sps_pkg::res_t ent_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign valid = cnt_q != 2'd0;
	assign space = cnt_q != 2'd2;
	assign pop   = valid && ready;
	assign dout  = ent_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

endmodule
